// ----- rtl/tmpl_pkg.sv -----
// Shared constants, types and helpers for the tone map lookup block.
package tmpl_pkg;

   localparam int MAP_DEPTH = 4096;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);

   // request payload layout, lowest bits first
   localparam int REQ_W = 72;
   localparam int RSP_W = 24;

   // quotient is 8 bits once the saturation case is taken out
   localparam int QUO_W          = 8;
   localparam int DIV_STAGES     = 4;
   localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;

   // pipeline stage positions
   localparam int S_IDX  = 0;
   localparam int S_LVL  = 1;
   localparam int S_MUL  = 2;
   localparam int S_DIV0 = 3;
   localparam int S_OUT  = S_DIV0 + DIV_STAGES;
   localparam int NSTG   = S_OUT + 1;

   localparam int NUM_LANES = 3;

   // request kind carried on tuser
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_MIN_BRIGHT = 3'd0;
   localparam logic [2:0] CSR_MAX_BRIGHT = 3'd1;
   localparam logic [2:0] CSR_RED_DIV    = 3'd2;
   localparam logic [2:0] CSR_GREEN_DIV  = 3'd3;
   localparam logic [2:0] CSR_BLUE_DIV   = 3'd4;
   localparam logic [2:0] CSR_MONO       = 3'd5;

   typedef struct packed {
      logic                  mul;
      logic [DIV_STAGES-1:0] div;
   } stage_en_type;

   typedef struct packed {
      logic       last;
      logic [7:0] grey;
   } side_type;

   function automatic logic [7:0] sat255(input logic [15:0] v);
      sat255 = (v > 16'd255) ? 8'hFF : v[7:0];
   endfunction

endpackage

// ----- rtl/tmpl_lane.sv -----
// One color lane: chroma times table level, then a pipelined restoring divide.
module tmpl_lane (
   input  logic                   clock,
   input  tmpl_pkg::stage_en_type en,
   input  logic [7:0]             chroma,
   input  logic [15:0]            level,
   input  logic [7:0]             divisor,
   output logic [7:0]             result
);
   import tmpl_pkg::*;

   logic [23:0] prod_in, prod_ff;

   logic [7:0] rem_ff [DIV_STAGES];
   logic [7:0] quo_ff [DIV_STAGES];
   logic [7:0] lo_ff  [DIV_STAGES];
   logic       sat_ff [DIV_STAGES];

   assign prod_in = 24'(chroma) * 24'(level);

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_ff <= prod_in;
      end
   end

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic [7:0] rem_src, quo_src, lo_src;
      logic       sat_src;
      logic [7:0] rem_in, quo_in, lo_in;
      logic       sat_in;

      if (j == 0) begin : g_first
         // quotient above 255 (or zero divisor) saturates; else the top
         // byte already sits below the divisor
         assign sat_src = prod_ff >= {8'd0, divisor, 8'd0};
         assign rem_src = prod_ff[15:8];
         assign lo_src  = prod_ff[7:0];
         assign quo_src = '0;
      end else begin : g_next
         assign sat_src = sat_ff[j-1];
         assign rem_src = rem_ff[j-1];
         assign lo_src  = lo_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end

      always_comb begin
         logic [8:0] t;
         sat_in = sat_src;
         rem_in = rem_src;
         lo_in  = lo_src;
         quo_in = quo_src;
         for (int s = 0; s < BITS_PER_STAGE; s++) begin
            t     = {rem_in, lo_in[7]};
            lo_in = {lo_in[6:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
               rem_in = 8'(t - {1'b0, divisor});
               quo_in = {quo_in[6:0], 1'b1};
            end else begin
               rem_in = t[7:0];
               quo_in = {quo_in[6:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en.div[j]) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            lo_ff[j]  <= lo_in;
            sat_ff[j] <= sat_in;
         end
      end
   end

   assign result = sat_ff[DIV_STAGES-1] ? 8'hFF : quo_ff[DIV_STAGES-1];

endmodule

// ----- rtl/tmpl_merge.sv -----
// Output register: combines the lane results or the grey level into one result.
module tmpl_merge (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic                                   mono,
   input  tmpl_pkg::side_type                     side,
   input  logic [tmpl_pkg::NUM_LANES-1:0][7:0]    lane_q,
   output logic [tmpl_pkg::RSP_W-1:0]             rsp_data,
   output logic                                   rsp_last
);
   import tmpl_pkg::*;

   logic [RSP_W-1:0] data_in, data_ff;
   logic             last_ff;

   always_comb begin
      if (mono) begin
         data_in = {8'd0, 8'd0, side.grey};
      end else begin
         data_in = {lane_q[2], lane_q[1], lane_q[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         last_ff <= side.last;
      end
   end

   assign rsp_data = data_ff;
   assign rsp_last = last_ff;

endmodule

// ----- rtl/tone_map_pixel_lut.sv -----
// Top level of the tone map lookup block: table, index stage, lanes, control.
//
// req channel: tuser is the kind (0 map a pixel, 1 write a table entry),
// tlast marks the last pixel of a scan. A load writes the table in the cycle
// it is accepted and produces no result. A pixel clamps its brightness, reads
// the 4096 x 16 table, and then either saturates the level to a grey byte
// (mono) or runs three lanes that multiply each chroma byte by the level and
// divide by that channel's divisor with a 4-stage restoring divider.
// rsp channel: one transaction per pixel, in order, tlast copied through.
// Throughput: one transaction per clock on req, loads and pixels alike; the
// eight pipeline stages each move on their own, so a stalled rsp only stops
// req once every stage holds a pixel.
// csr port: write enable, index, data; the user must see it written only while
// the block is idle, which the block itself does not enforce.
// Reset: pipeline emptied, registers to defaults (divisors 255, bounds 0,
// color mode). Table contents are not cleared; load every entry before use.
module tone_map_pixel_lut (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // brightness, chroma_red, chroma_green, chroma_blue, entry_index,
   // entry_value, then zero pad
   input  logic [tmpl_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        req_tuser,   // cmd
   input  logic                        req_tlast,   // last_in
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_red, out_green, out_blue
   output logic [tmpl_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,   // last_out
   input  logic                        csr_wen,
   input  logic [2:0]                  csr_addr,
   input  logic [15:0]                 csr_wdata
);
   import tmpl_pkg::*;

   // configuration
   logic signed [15:0] min_ff, max_ff;
   logic [NUM_LANES-1:0][7:0] div_ff;
   logic                      mono_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         max_ff  <= '0;
         div_ff  <= {NUM_LANES{8'hFF}};
         mono_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_MIN_BRIGHT: min_ff    <= csr_wdata;
            CSR_MAX_BRIGHT: max_ff    <= csr_wdata;
            CSR_RED_DIV:    div_ff[0] <= csr_wdata[7:0];
            CSR_GREEN_DIV:  div_ff[1] <= csr_wdata[7:0];
            CSR_BLUE_DIV:   div_ff[2] <= csr_wdata[7:0];
            CSR_MONO:       mono_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // request fields
   logic signed [15:0]        req_bright;
   logic [NUM_LANES-1:0][7:0] req_chroma;
   logic [11:0]               req_entry_idx;
   logic [15:0]               req_entry_val;

   assign req_bright    = req_tdata[15:0];
   assign req_chroma    = req_tdata[39:16];
   assign req_entry_idx = req_tdata[51:40];
   assign req_entry_val = req_tdata[67:52];

   // stage control
   logic [NSTG-1:0] valid_ff;
   logic [NSTG:0]   ready;
   logic            pix_acc, load_acc;

   always_comb begin
      ready[NSTG] = rsp_tready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_tready = ready[S_IDX];
   assign pix_acc    = req_tvalid && req_tready && (req_tuser == CMD_PIXEL);
   assign load_acc   = req_tvalid && req_tready && (req_tuser == CMD_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[S_IDX]) begin
            valid_ff[S_IDX] <= pix_acc;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // index stage: clamp, offset from the floor, saturate to table depth
   logic signed [15:0] clamp;
   logic signed [16:0] offset;
   logic [MAP_AW-1:0]  idx_in, idx_ff;
   logic [NUM_LANES-1:0][7:0] chroma_s0_ff, chroma_s1_ff;

   always_comb begin
      if (req_bright < min_ff) begin
         clamp = min_ff;
      end else if (req_bright > max_ff) begin
         clamp = max_ff;
      end else begin
         clamp = req_bright;
      end
      offset = {clamp[15], clamp} - {min_ff[15], min_ff};
      // negative only when the floor sits above the ceiling
      if (offset[16]) begin
         idx_in = '0;
      end else if ({16'd0, offset[15:0]} >= 32'(MAP_DEPTH)) begin
         idx_in = MAP_AW'(MAP_DEPTH - 1);
      end else begin
         idx_in = MAP_AW'(offset[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[S_IDX]) begin
         idx_ff       <= idx_in;
         chroma_s0_ff <= req_chroma;
      end
   end

   // table: load writes at accept, pixel reads leaving the index stage
   logic [15:0] map_mem [MAP_DEPTH];
   logic [15:0] level_ff;

   always_ff @(posedge clock) begin
      if (load_acc && ({20'd0, req_entry_idx} < 32'(MAP_DEPTH))) begin
         map_mem[MAP_AW'(req_entry_idx)] <= req_entry_val;
      end
      if (ready[S_LVL]) begin
         level_ff     <= map_mem[idx_ff];
         chroma_s1_ff <= chroma_s0_ff;
      end
   end

   // tlast and grey level ride alongside the lanes
   side_type side_ff [NSTG-1];

   always_ff @(posedge clock) begin
      if (ready[S_IDX]) begin
         side_ff[S_IDX] <= '{last: req_tlast, grey: 8'd0};
      end
      for (int k = 1; k < NSTG - 1; k++) begin
         if (ready[k]) begin
            if (k == S_MUL) begin
               side_ff[k] <= '{last: side_ff[k-1].last, grey: sat255(level_ff)};
            end else begin
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   end

   // color lanes
   stage_en_type              lane_en;
   logic [NUM_LANES-1:0][7:0] lane_q;

   assign lane_en.mul = ready[S_MUL];
   assign lane_en.div = ready[S_OUT-1:S_DIV0];

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      tmpl_lane u_lane (
         .clock   (clock),
         .en      (lane_en),
         .chroma  (chroma_s1_ff[i]),
         .level   (level_ff),
         .divisor (div_ff[i]),
         .result  (lane_q[i])
      );
   end

   tmpl_merge u_merge (
      .clock    (clock),
      .en       (ready[S_OUT]),
      .mono     (mono_ff),
      .side     (side_ff[NSTG-2]),
      .lane_q   (lane_q),
      .rsp_data (rsp_tdata),
      .rsp_last (rsp_tlast)
   );

   assign rsp_tvalid = valid_ff[S_OUT];

   // a pixel taken in always occupies the index stage next cycle
   a_pix_enters: assert property (@(posedge clock) disable iff (reset)
      pix_acc |=> valid_ff[S_IDX])
      else $error("accepted pixel did not enter the index stage");

   // an item leaving the last divide stage lands in the output register
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_OUT-1] && ready[S_OUT] |=> valid_ff[S_OUT])
      else $error("item lost between divide and output stage");

   // table read data holds while its stage is stalled
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_LVL] && !ready[S_LVL] |=> $stable(level_ff))
      else $error("table read data changed under a stall");

endmodule
